@@ hdl/cobs_enc_pkg.sv @@
// ----------------------------------------------------------------------------
// COBS frame encoder package
// Shared constants, controller state, and the command/status bundles that
// join the encoder controller to its datapath.
// ----------------------------------------------------------------------------
package cobs_enc_pkg;

  localparam int BYTE_W             = 8;
  localparam int WORD_BYTES_MAX     = 8;
  localparam int OUT_W              = WORD_BYTES_MAX * BYTE_W;  // out_bytes
  localparam int CNT_W              = 4;                        // byte_count
  localparam int TDATA_W            = 72;                       // 68 bits, byte padded
  localparam int BYTES_PER_WORD_DEF = 8;

  localparam int BLOCK_DEPTH = 254;   // max held bytes of one block
  localparam int IDX_W       = 8;     // index into the block store

  localparam logic [BYTE_W-1:0] FULL_CODE = 8'hFF;
  localparam logic [BYTE_W-1:0] DELIM     = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,    // leading delimiter
    ST_CODE,    // code byte of a block
    ST_HELD,    // held bytes of a block
    ST_TRAIL    // trailing delimiter
  } state_e;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_CODE,
    SEL_HELD
  } byte_sel_e;

  typedef struct packed {
    logic      take;        // input request accepted this cycle
    logic      emit;        // append one output byte this cycle
    byte_sel_e sel;         // source of that byte
    logic      fin;         // the byte is the last one caused by the request
    logic      idx_clr;     // restart block store read index
    logic      idx_inc;     // step block store read index
    logic      flush_done;  // block written out, code count back to one
  } cmd_t;

  typedef struct packed {
    logic in_lead;         // incoming request opens a frame with a delimiter
    logic in_flush1;       // incoming byte closes a block (zero or full)
    logic in_last;         // incoming byte ends the frame
    logic flush1_q;        // latched in_flush1
    logic last_q;          // latched in_last
    logic delim;           // delimiter register
    logic code_one;        // block holds no bytes
    logic held_last;       // read index at the final held byte
    logic pack_near_full;  // next byte completes an output word
    logic out_free;        // output register can take a word this cycle
  } sts_t;

endpackage

@@ hdl/cobs_enc_ctrl.sv @@
// ----------------------------------------------------------------------------
// COBS encoder controller
// Sequences the output bytes of one request: leading delimiter, up to two
// blocks (code then held bytes), trailing delimiter.
// ----------------------------------------------------------------------------
module cobs_enc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  cobs_enc_pkg::sts_t  sts_i,
  output cobs_enc_pkg::cmd_t  cmd_o
);
  import cobs_enc_pkg::*;

  state_e state_q, state_d;
  logic   pass_q, pass_d;     // set while writing the second block
  logic   more_flush;
  logic   flush_end;
  logic   fin;
  logic   trail;

  assign more_flush  = sts_i.flush1_q && sts_i.last_q && !pass_q;
  assign trail       = sts_i.last_q && sts_i.delim;
  assign req_ready_o = (state_q == ST_IDLE);

  // outputs
  always_comb begin
    cmd_o     = '0;
    cmd_o.sel = SEL_ZERO;
    flush_end = 1'b0;
    fin       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take = req_valid_i;
      end
      ST_LEAD: begin
        fin = !sts_i.flush1_q && !sts_i.last_q;
      end
      ST_CODE: begin
        cmd_o.sel     = SEL_CODE;
        cmd_o.idx_clr = 1'b1;
        flush_end     = sts_i.code_one;
        fin           = sts_i.code_one && !more_flush && !trail;
      end
      ST_HELD: begin
        cmd_o.sel = SEL_HELD;
        flush_end = sts_i.held_last;
        fin       = sts_i.held_last && !more_flush && !trail;
      end
      ST_TRAIL: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
    if (state_q != ST_IDLE) begin
      // a byte that completes a word or ends the request needs room in the output register
      cmd_o.emit = !(fin || sts_i.pack_near_full) || sts_i.out_free;
    end
    cmd_o.fin        = fin;
    cmd_o.idx_inc    = (state_q == ST_HELD) && cmd_o.emit;
    cmd_o.flush_done = flush_end && cmd_o.emit;
  end

  // next state
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.take) begin
          pass_d = 1'b0;
          if (sts_i.in_lead) begin
            state_d = ST_LEAD;
          end else if (sts_i.in_flush1 || sts_i.in_last) begin
            state_d = ST_CODE;
          end
        end
      end
      ST_LEAD: begin
        if (cmd_o.emit) begin
          state_d = fin ? ST_IDLE : ST_CODE;
        end
      end
      ST_CODE, ST_HELD: begin
        if (cmd_o.emit) begin
          if (!flush_end) begin
            state_d = ST_HELD;
          end else if (more_flush) begin
            state_d = ST_CODE;
            pass_d  = 1'b1;
          end else if (trail) begin
            state_d = ST_TRAIL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TRAIL: begin
        if (cmd_o.emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule

@@ hdl/cobs_enc_dp.sv @@
// ----------------------------------------------------------------------------
// COBS encoder datapath
// Block store, code count, frame state, word packer and output register.
// ----------------------------------------------------------------------------
module cobs_enc_dp #(
  parameter int BYTES_PER_WORD = cobs_enc_pkg::BYTES_PER_WORD_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_wdata_i,
  input  logic [cobs_enc_pkg::BYTE_W-1:0]      in_byte_i,
  input  logic                                 in_last_i,
  input  cobs_enc_pkg::cmd_t                   cmd_i,
  output cobs_enc_pkg::sts_t                   sts_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [cobs_enc_pkg::OUT_W-1:0]       out_bytes_o,
  output logic [cobs_enc_pkg::CNT_W-1:0]       out_count_o,
  output logic                                 out_run_end_o,
  output logic                                 out_frame_end_o
);
  import cobs_enc_pkg::*;

  logic [BYTE_W-1:0] mem [BLOCK_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic [BYTE_W-1:0] count_q, count_d;
  logic              started_q, delim_q, flush1_q, last_q;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic [OUT_W-1:0]  pack_q, pack_d, pack_ins;
  logic [CNT_W-1:0]  pack_cnt_q, pack_cnt_d;
  logic              push;
  logic [BYTE_W-1:0] emit_byte;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_bytes_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_run_q, out_frame_q;

  logic in_zero;
  assign in_zero = (in_byte_i == DELIM);

  // status
  always_comb begin
    sts_o                = '0;
    sts_o.in_lead        = !started_q && delim_q;
    sts_o.in_flush1      = in_zero || (count_q == FULL_CODE - 8'd1);
    sts_o.in_last        = in_last_i;
    sts_o.flush1_q       = flush1_q;
    sts_o.last_q         = last_q;
    sts_o.delim          = delim_q;
    sts_o.code_one       = (count_q == 8'd1);
    sts_o.held_last      = (idx_q == count_q - 8'd2);
    sts_o.pack_near_full = (pack_cnt_q == CNT_W'(BYTES_PER_WORD - 1));
    sts_o.out_free       = !out_valid_q || out_ready_i;
  end

  // code count and read index
  always_comb begin
    count_d = count_q;
    if (cmd_i.take && !in_zero) begin
      count_d = count_q + 8'd1;
    end else if (cmd_i.flush_done) begin
      count_d = 8'd1;
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // block store: one write per accepted nonzero byte, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !in_zero) begin
      mem[count_q - 8'd1] <= in_byte_i;
    end
    rdata_q <= mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 8'd1;
      started_q <= 1'b0;
      delim_q   <= 1'b1;
      flush1_q  <= 1'b0;
      last_q    <= 1'b0;
      idx_q     <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
      if (cmd_i.take) begin
        started_q <= !in_last_i;
        flush1_q  <= sts_o.in_flush1;
        last_q    <= in_last_i;
      end
    end
  end

  // word packer
  always_comb begin
    case (cmd_i.sel)
      SEL_CODE: emit_byte = count_q;
      SEL_HELD: emit_byte = rdata_q;
      default:  emit_byte = DELIM;
    endcase
    pack_ins = pack_q;
    for (int j = 0; j < WORD_BYTES_MAX; j++) begin
      if ((j < BYTES_PER_WORD) && (pack_cnt_q == CNT_W'(j))) begin
        pack_ins[j*BYTE_W +: BYTE_W] = emit_byte;
      end
    end
    push       = cmd_i.emit && (cmd_i.fin || sts_o.pack_near_full);
    pack_d     = pack_q;
    pack_cnt_d = pack_cnt_q;
    if (push) begin
      pack_d     = '0;
      pack_cnt_d = '0;
    end else if (cmd_i.emit) begin
      pack_d     = pack_ins;
      pack_cnt_d = pack_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q      <= '0;
      pack_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pack_q     <= pack_d;
      pack_cnt_q <= pack_cnt_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_bytes_q <= pack_ins;
      out_cnt_q   <= pack_cnt_q + 1'b1;
      out_run_q   <= cmd_i.fin;
      out_frame_q <= cmd_i.fin && last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_bytes_o     = out_bytes_q;
  assign out_count_o     = out_cnt_q;
  assign out_run_end_o   = out_run_q;
  assign out_frame_end_o = out_frame_q;

endmodule

@@ hdl/cobs_frame_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// COBS frame encoder
// Byte-in, word-out Consistent Overhead Byte Stuffing encoder with optional
// zero delimiters around each frame.
// ----------------------------------------------------------------------------
// Raw frame bytes enter one per request on the slave stream, tlast on the
// final byte of a frame; the encoded frame leaves as words of up to
// BYTES_PER_WORD bytes, first byte in bits 7:0, with the valid byte count
// beside it. A nonzero byte that neither opens a delimited frame nor closes a
// block makes no output. Any other request closes the intake until the
// byte-serial emitter has released its encoded bytes in order (leading
// delimiter, code byte, held bytes, second code byte, trailing delimiter);
// master side stalls keep it closed longer. The emitter reads the 254-entry
// block store one byte per cycle while the master side does not stall. The
// block store needs no clearing pass: only bytes written in the open block are read.
// cfg_wdata_i sets the delimiter option (reset 1); write it between requests.
module cobs_frame_encoder_unit #(
  parameter int BYTES_PER_WORD = cobs_enc_pkg::BYTES_PER_WORD_DEF  // 1..8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // delimiter option
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  // raw bytes
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [7:0]                          s_axis_tdata_i,   // [7:0] data_byte
  input  logic                                s_axis_tlast_i,   // last_byte
  // encoded words
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [cobs_enc_pkg::TDATA_W-1:0]    m_axis_tdata_o,   // [63:0] out_bytes,
                                                                // [67:64] byte_count,
                                                                // [71:68] zero
  output logic                                m_axis_tuser_o,   // run_end
  output logic                                m_axis_tlast_o    // frame_end
);
  import cobs_enc_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [OUT_W-1:0]  out_bytes;
  logic [CNT_W-1:0]  out_cnt;

  cobs_enc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cobs_enc_dp #(
    .BYTES_PER_WORD (BYTES_PER_WORD)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_byte_i       (s_axis_tdata_i),
    .in_last_i       (s_axis_tlast_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_bytes_o     (out_bytes),
    .out_count_o     (out_cnt),
    .out_run_end_o   (m_axis_tuser_o),
    .out_frame_end_o (m_axis_tlast_o)
  );

  // pad the 68 payload bits to whole bytes
  assign m_axis_tdata_o = {(TDATA_W - OUT_W - CNT_W)'(0), out_cnt, out_bytes};

endmodule

@@ hdl/cobs_enc_checker.sv @@
// ----------------------------------------------------------------------------
// COBS encoder port checker
// Port-level checks on the encoder's streams, bound to the top level.
// ----------------------------------------------------------------------------
module cobs_enc_checker #(
  parameter int BYTES_PER_WORD = cobs_enc_pkg::BYTES_PER_WORD_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              s_axis_tlast_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [cobs_enc_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  input logic                              m_axis_tuser_o,
  input logic                              m_axis_tlast_o
);
  import cobs_enc_pkg::*;

  logic [CNT_W-1:0] cnt;
  assign cnt = m_axis_tdata_o[OUT_W +: CNT_W];

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed under back-pressure");

  // word carries between one and BYTES_PER_WORD bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cnt != '0) && (cnt <= CNT_W'(BYTES_PER_WORD)))
    else $error("byte count out of range");

  // end of frame is always the end of its request's output
  a_frame_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("frame end without run end");

  // a final byte always releases output, so intake pauses
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("intake open right after frame end");

endmodule

bind cobs_frame_encoder_unit cobs_enc_checker #(
  .BYTES_PER_WORD (BYTES_PER_WORD)
) u_cobs_enc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

@@ sim/cobs_encode_check.sv @@
// ----------------------------------------------------------------------------
// COBS encoder stream checker
// Watches the delimiter register, the byte stream and the word stream,
// predicts the encoded words and compares each one as it leaves.
// ----------------------------------------------------------------------------
module cobs_encode_check #(
  parameter int BYTES_PER_WORD = cobs_enc_pkg::BYTES_PER_WORD_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [7:0]                       in_data_i,
  input  logic                             in_last_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [cobs_enc_pkg::TDATA_W-1:0] out_data_i,
  input  logic                             out_user_i,
  input  logic                             out_last_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);
  import cobs_enc_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] bytes;
    logic [CNT_W-1:0] count;
    logic             run_end;
    logic             frame_end;
  } enc_word_t;

  enc_word_t         words_due_q[$];
  logic [BYTE_W-1:0] byte_run_q[$];   // encoded bytes of the current request
  logic [BYTE_W-1:0] held_bytes[BLOCK_DEPTH];
  logic [BYTE_W-1:0] code_cnt;
  logic              frame_open;
  logic              delim_on;
  int unsigned       errors = 0;
  enc_word_t         due;

  task automatic flag_error(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    errors++;
    $display("[%0t] encoder mismatch, %s: got %h want %h", $time, what, got, want);
  endtask

  // code byte, then the held bytes, block restarts
  task automatic close_block();
    for (int i = 0; i < int'(code_cnt) - 1; i++) byte_run_q.push_back(held_bytes[i]);
    byte_run_q.insert(byte_run_q.size() - (int'(code_cnt) - 1), code_cnt);
    code_cnt = 8'd1;
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    enc_word_t w;
    int        pos;
    int        n;
    byte_run_q.delete();
    if (!frame_open) begin
      if (delim_on) byte_run_q.push_back(DELIM);
      frame_open = 1'b1;
    end
    if (b == DELIM) begin
      close_block();
    end else begin
      held_bytes[code_cnt - 8'd1] = b;
      code_cnt++;
      if (code_cnt == FULL_CODE) close_block();
    end
    if (fin) begin
      close_block();
      if (delim_on) byte_run_q.push_back(DELIM);
      frame_open = 1'b0;
    end
    // pack into words, first byte lowest
    pos = 0;
    while (pos < byte_run_q.size()) begin
      n = byte_run_q.size() - pos;
      if (n > BYTES_PER_WORD) n = BYTES_PER_WORD;
      w = '0;
      for (int j = 0; j < n; j++) w.bytes[8*j +: 8] = byte_run_q[pos + j];
      pos += n;
      w.count     = CNT_W'(n);
      w.run_end   = (pos == byte_run_q.size());
      w.frame_end = fin && w.run_end;
      words_due_q.push_back(w);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_due_q.delete();
      code_cnt   = 8'd1;
      frame_open = 1'b0;
      delim_on   = 1'b1;
    end else begin
      // outputs first: a word leaving now never belongs to a request taken now
      if (out_valid_i && out_ready_i) begin
        if (words_due_q.size() == 0) begin
          flag_error("word with nothing due", out_data_i[63:0], '0);
        end else begin
          due = words_due_q.pop_front();
          if (out_data_i[OUT_W-1:0] !== due.bytes)
            flag_error("out_bytes", out_data_i[OUT_W-1:0], due.bytes);
          if (out_data_i[OUT_W +: CNT_W] !== due.count)
            flag_error("byte_count", 64'(out_data_i[OUT_W +: CNT_W]), 64'(due.count));
          if (out_user_i !== due.run_end)
            flag_error("run_end", 64'(out_user_i), 64'(due.run_end));
          if (out_last_i !== due.frame_end)
            flag_error("frame_end", 64'(out_last_i), 64'(due.frame_end));
        end
      end
      if (cfg_we_i) delim_on = cfg_wdata_i;
      if (in_valid_i && in_ready_i) encode_byte(in_data_i, in_last_i);
    end
    pending_o    <= words_due_q.size();
    fail_count_o <= errors;
  end

endmodule

@@ sim/cobs_frame_encoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// COBS frame encoder testbench
// Directed frames for the corner cases, then random frames under random
// stalls on both streams and all delimiter settings; a stream checker
// predicts every encoded word and reports mismatches.
// ----------------------------------------------------------------------------
module cobs_frame_encoder_unit_tb;
  import cobs_enc_pkg::*;

  localparam int BPW            = 8;
  localparam int HOLD_CYCLES    = 400;   // long receiver back-pressure
  localparam int SETTLE_CYCLES  = 300;   // covers a full-block flush
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS    = 30;    // per random phase; ~380 requests overall

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               s_tvalid  = 1'b0;
  logic [7:0]         s_tdata   = 8'h00;
  logic               s_tlast   = 1'b0;
  logic               s_tready;
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned idle_cycles = 0;
  int unsigned sent        = 0;
  bit          calm        = 1'b0;  // no gaps on either side
  bit          hold_req    = 1'b0;  // ask the receiver for a long hold-off

  cobs_frame_encoder_unit #(.BYTES_PER_WORD(BPW)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  cobs_encode_check #(.BYTES_PER_WORD(BPW)) u_encode_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (s_tvalid),
    .in_ready_i   (s_tready),
    .in_data_i    (s_tdata),
    .in_last_i    (s_tlast),
    .out_valid_i  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_data_i   (m_tdata),
    .out_user_i   (m_tuser),
    .out_last_i   (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (words_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // mostly short gaps, a few long ones; none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte(input int unsigned zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return DELIM;
    if ($urandom_range(0, 9) == 0) return 8'hFF;
    return 8'($urandom_range(1, 255));
  endfunction

  // one request on the byte stream; valid stays up when no gap follows
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input int unsigned len, input int unsigned zero_pct);
    for (int unsigned i = 0; i < len; i++) push_byte(pick_byte(zero_pct), i == len - 1);
  endtask

  // register write only once the encoder has drained
  task automatic write_delim(input logic v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random ready pattern, plus the requested long hold-off
  initial begin
    int unsigned on_len;
    int unsigned off_len;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= 1'b1;
        on_len = $urandom_range(1, 16);
        repeat (on_len) @(posedge clk);
        off_len = pick_gap();
        if (off_len != 0) begin
          m_tready <= 1'b0;
          repeat (off_len) @(posedge clk);
        end
      end
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_start;
    int unsigned len;
    int unsigned r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: delimiters on from reset
    push_byte(8'h00, 1'b1);                       // lone zero
    push_byte(8'hFF, 1'b1);                       // top byte value
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h00, 1'b0);                       // back-to-back zeros
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b0);                       // nonzero mid-frame: no output
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b1);
    // delimiter option flipped inside a frame, both ways
    push_byte(8'h33, 1'b0);
    write_delim(1'b0);
    push_byte(8'h44, 1'b1);
    push_byte(8'h55, 1'b0);
    write_delim(1'b1);
    push_byte(8'h66, 1'b1);
    write_delim(1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hA5, 1'b1);

    // random phases, alternating delimiter setting
    for (int ph = 0; ph < 4; ph++) begin
      write_delim(ph[0]);
      phase_start = sent;
      if (ph == 1) begin
        // 254 nonzero bytes ending the frame: full block plus a lone code;
        // sent without gaps so the flush lands inside the receiver hold-off
        // and the input stalls
        calm     = 1'b1;
        hold_req = 1'b1;
        send_frame(254, 0);
      end
      while (sent - phase_start < PHASE_ITEMS) begin
        calm = ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 12);
        else if (r < 95) len = $urandom_range(13, 40);
        else             len = $urandom_range(41, 120);
        case ($urandom_range(0, 4))
          0:       send_frame(len, 0);
          1:       send_frame(len, 5);
          2:       send_frame(len, 20);
          3:       send_frame(len, 50);
          default: send_frame(len, 90);
        endcase
      end
      calm = 1'b0;
    end

    // drain
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
